[rtl/core/bpps_pkg.sv]
`timescale 1ns / 1ps
package bpps_pkg;
	localparam int DIR_FRAC_BITS = 14;

	// normalized magnitude width: largest component lands in [2^30, 2^31)
	localparam int NORM_W     = 31;
	localparam int SQ_SUM_W   = 64;
	localparam int ROOT_STEPS = 32;
	localparam int LEN_W      = 32;

	localparam int DIR_W      = 16;
	localparam int POS_W      = 32;
	localparam int RGB_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIGHT_X    = 3'd0,
		CFG_LIGHT_Y    = 3'd1,
		CFG_LIGHT_Z    = 3'd2,
		CFG_CAMERA_X   = 3'd3,
		CFG_CAMERA_Y   = 3'd4,
		CFG_CAMERA_Z   = 3'd5,
		CFG_OBJECT_RGB = 3'd6
	} cfg_idx_t;

	localparam logic signed [DIR_W-1:0] LIGHT_X_RST  = -16'sd11148;
	localparam logic signed [DIR_W-1:0] LIGHT_Y_RST  = -16'sd4460;
	localparam logic signed [DIR_W-1:0] LIGHT_Z_RST  = 16'sd11148;
	localparam logic signed [POS_W-1:0] CAMERA_X_RST = 32'sd0;
	localparam logic signed [POS_W-1:0] CAMERA_Y_RST = 32'sd327680;
	localparam logic signed [POS_W-1:0] CAMERA_Z_RST = -32'sd1310720;
	localparam logic [RGB_W-1:0]        OBJECT_RGB_RST = 24'd3933384;
endpackage

[rtl/core/blinn_phong_pixel_shader.sv]
`timescale 1ns / 1ps
// Channel  Handshake                 Beat payload
// -------  ------------------------  -------------------------------------------
// in       in_valid / in_ready       normal_x/y/z (Q1.14), pos_x/y/z (Q16.16)
// out      out_valid / out_ready     red, green, blue, degenerate
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data (write only)
//
// One fragment enters per clock unless a result is held on out. Each fragment
// goes through two normalizer passes of DIR_FRAC_BITS + 38 stages each, set by
// the 32-step square root and the one-bit-per-stage divider, then 13 stages of
// dot products, six squarings and color scaling.
// arst_n clears all valid bits and loads the default light, camera and color.
// A result held on out with out_ready low freezes the whole pipeline; in_ready
// drops in the same cycle, so nothing is lost or repeated. cfg_ready is
// always high; write registers only while the pipeline is empty.
module blinn_phong_pixel_shader #(
	parameter int DIR_FRAC_BITS = bpps_pkg::DIR_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [bpps_pkg::DIR_W-1:0]     normal_x,
	input  logic signed [bpps_pkg::DIR_W-1:0]     normal_y,
	input  logic signed [bpps_pkg::DIR_W-1:0]     normal_z,
	input  logic signed [bpps_pkg::POS_W-1:0]     pos_x,
	input  logic signed [bpps_pkg::POS_W-1:0]     pos_y,
	input  logic signed [bpps_pkg::POS_W-1:0]     pos_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bpps_pkg::CHAN_W-1:0]           red,
	output logic [bpps_pkg::CHAN_W-1:0]           green,
	output logic [bpps_pkg::CHAN_W-1:0]           blue,
	output logic                                  degenerate,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bpps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bpps_pkg::CFG_DATA_W-1:0]       cfg_data
);
	localparam int F    = DIR_FRAC_BITS;
	localparam int DW   = bpps_pkg::DIR_W;
	localparam int PSW  = bpps_pkg::POS_W;
	localparam int CW   = bpps_pkg::CHAN_W;
	localparam int UW   = F + 2;           // signed unit component
	localparam int HW   = F + 3;           // halfway sum before normalizing
	localparam int PRW  = 2 * UW;          // one dot-product term
	localparam int DOTW = PRW + 2;         // three terms summed
	localparam int IW   = F + 2;           // intensity, below 2.0
	localparam int CPW  = IW + CW;         // intensity times color
	localparam int XW   = F + CW;          // product range once below the cap
	localparam int RK   = F + 10;          // reciprocal scale
	localparam int MW   = F + 3;
	localparam int QMW  = XW + MW;

	localparam logic [F:0]     ONE   = {1'b1, {F{1'b0}}};
	localparam logic [IW-1:0]  AMB   = IW'((longint'(15) << F) / 100);
	localparam logic [CPW-1:0] LIMIT = CPW'(longint'(255) * ((longint'(1) << F) + 1));
	localparam logic [MW-1:0]  RECIP = MW'((longint'(1) << RK) / 255);

	typedef struct packed {
		logic                 dg;
		logic signed [UW-1:0] nx;
		logic signed [UW-1:0] ny;
		logic signed [UW-1:0] nz;
		logic signed [UW-1:0] lx;
		logic signed [UW-1:0] ly;
		logic signed [UW-1:0] lz;
	} htag_t;

	localparam int TW = $bits(htag_t);

	// configuration registers
	logic signed [DW-1:0]            light_x_q, light_y_q, light_z_q;
	logic signed [PSW-1:0]           camera_x_q, camera_y_q, camera_z_q;
	logic [bpps_pkg::RGB_W-1:0]      object_rgb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q    <= bpps_pkg::LIGHT_X_RST;
			light_y_q    <= bpps_pkg::LIGHT_Y_RST;
			light_z_q    <= bpps_pkg::LIGHT_Z_RST;
			camera_x_q   <= bpps_pkg::CAMERA_X_RST;
			camera_y_q   <= bpps_pkg::CAMERA_Y_RST;
			camera_z_q   <= bpps_pkg::CAMERA_Z_RST;
			object_rgb_q <= bpps_pkg::OBJECT_RGB_RST;
		end else if (cfg_valid) begin
			case (bpps_pkg::cfg_idx_t'(cfg_index))
				bpps_pkg::CFG_LIGHT_X:    light_x_q    <= cfg_data[DW-1:0];
				bpps_pkg::CFG_LIGHT_Y:    light_y_q    <= cfg_data[DW-1:0];
				bpps_pkg::CFG_LIGHT_Z:    light_z_q    <= cfg_data[DW-1:0];
				bpps_pkg::CFG_CAMERA_X:   camera_x_q   <= cfg_data[PSW-1:0];
				bpps_pkg::CFG_CAMERA_Y:   camera_y_q   <= cfg_data[PSW-1:0];
				bpps_pkg::CFG_CAMERA_Z:   camera_z_q   <= cfg_data[PSW-1:0];
				bpps_pkg::CFG_OBJECT_RGB: object_rgb_q <= cfg_data[bpps_pkg::RGB_W-1:0];
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// global advance: every stage moves unless a finished beat is held at out
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// light is negated, view vector is camera minus fragment
	logic signed [DW:0]  lneg_x, lneg_y, lneg_z;
	logic signed [PSW:0] view_x, view_y, view_z;

	assign lneg_x = -{light_x_q[DW-1], light_x_q};
	assign lneg_y = -{light_y_q[DW-1], light_y_q};
	assign lneg_z = -{light_z_q[DW-1], light_z_q};
	assign view_x = {camera_x_q[PSW-1], camera_x_q} - {pos_x[PSW-1], pos_x};
	assign view_y = {camera_y_q[PSW-1], camera_y_q} - {pos_y[PSW-1], pos_y};
	assign view_z = {camera_z_q[PSW-1], camera_z_q} - {pos_z[PSW-1], pos_z};

	// first pass: N, L and V normalized side by side
	logic                 n_valid, n_zero, l_zero, v_zero;
	logic signed [UW-1:0] n_x, n_y, n_z, l_x, l_y, l_z, v_x, v_y, v_z;
	logic                 n_tag;

	bpps_unit #(.W(DW), .F(F), .TW(1)) u_norm_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_x(normal_x), .in_y(normal_y), .in_z(normal_z), .in_tag(1'b0),
		.out_valid(n_valid), .out_x(n_x), .out_y(n_y), .out_z(n_z),
		.out_zero(n_zero), .out_tag(n_tag)
	);

	bpps_unit #(.W(DW + 1), .F(F), .TW(1)) u_norm_l (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_x(lneg_x), .in_y(lneg_y), .in_z(lneg_z), .in_tag(1'b0),
		.out_valid(), .out_x(l_x), .out_y(l_y), .out_z(l_z),
		.out_zero(l_zero), .out_tag()
	);

	bpps_unit #(.W(PSW + 1), .F(F), .TW(1)) u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_x(view_x), .in_y(view_y), .in_z(view_z), .in_tag(1'b0),
		.out_valid(), .out_x(v_x), .out_y(v_y), .out_z(v_z),
		.out_zero(v_zero), .out_tag()
	);

	// second pass: halfway vector; N and L ride along in the tag
	logic signed [HW-1:0] hin_x, hin_y, hin_z;
	htag_t                hin_tag, h_tag;
	logic                 h_valid, h_zero;
	logic signed [UW-1:0] h_x, h_y, h_z;

	assign hin_x = HW'(l_x) + HW'(v_x);
	assign hin_y = HW'(l_y) + HW'(v_y);
	assign hin_z = HW'(l_z) + HW'(v_z);
	assign hin_tag = '{dg: n_zero | l_zero | v_zero | n_tag,
		nx: n_x, ny: n_y, nz: n_z, lx: l_x, ly: l_y, lz: l_z};

	bpps_unit #(.W(HW), .F(F), .TW(TW)) u_norm_h (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(n_valid),
		.in_x(hin_x), .in_y(hin_y), .in_z(hin_z), .in_tag(hin_tag),
		.out_valid(h_valid), .out_x(h_x), .out_y(h_y), .out_z(h_z),
		.out_zero(h_zero), .out_tag(h_tag)
	);

	// stage 1: dot-product terms
	logic                      v_s1, dg_s1;
	logic signed [2:0][PRW-1:0] nl_s1, nh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= h_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1    <= h_tag.dg | h_zero;
			nl_s1[0] <= PRW'(h_tag.nx) * PRW'(h_tag.lx);
			nl_s1[1] <= PRW'(h_tag.ny) * PRW'(h_tag.ly);
			nl_s1[2] <= PRW'(h_tag.nz) * PRW'(h_tag.lz);
			nh_s1[0] <= PRW'(h_tag.nx) * PRW'(h_x);
			nh_s1[1] <= PRW'(h_tag.ny) * PRW'(h_y);
			nh_s1[2] <= PRW'(h_tag.nz) * PRW'(h_z);
		end
	end

	// stage 2: sum and clamp to [0, 1.0]
	function automatic logic [F:0] clamp_dot(input logic signed [DOTW-1:0] d);
		logic signed [DOTW-1:0] sh;
		logic [F:0]             res;
		sh = d >>> F;
		if (d <= 0)
			res = '0;
		else if (sh > $signed(DOTW'(ONE)))
			res = ONE;
		else
			res = sh[F:0];
		return res;
	endfunction

	logic signed [DOTW-1:0] nl_dot_c, nh_dot_c;
	logic [F:0]             pw_s [7];
	logic [F:0]             df_s [7];
	logic                   dg_s [7];
	logic                   vp_s [7];

	// a term picked out of the packed array is unsigned: re-sign before widening
	assign nl_dot_c = DOTW'($signed(nl_s1[0])) + DOTW'($signed(nl_s1[1]))
		+ DOTW'($signed(nl_s1[2]));
	assign nh_dot_c = DOTW'($signed(nh_s1[0])) + DOTW'($signed(nh_s1[1]))
		+ DOTW'($signed(nh_s1[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vp_s[0] <= 1'b0;
		else if (en) vp_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s[0] <= clamp_dot(nh_dot_c);
			df_s[0] <= clamp_dot(nl_dot_c);
			dg_s[0] <= dg_s1;
		end
	end

	// six squarings, one per stage: spec^64
	for (genvar k = 0; k < 6; k++) begin : g_pow
		logic [2*F+1:0] sqr;

		assign sqr = (2*F+2)'(pw_s[k]) * (2*F+2)'(pw_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vp_s[k+1] <= 1'b0;
			else if (en) vp_s[k+1] <= vp_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s[k+1] <= sqr[2*F:F];
				df_s[k+1] <= df_s[k];
				dg_s[k+1] <= dg_s[k];
			end
		end
	end

	// stage 3: intensity = ambient + diffuse + spec/2
	logic           v_s3, dg_s3;
	logic [IW-1:0]  inten_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= vp_s[6];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inten_s3 <= AMB + IW'(df_s[6]) + IW'(pw_s[6] >> 1);
			dg_s3    <= dg_s[6];
		end
	end

	// stage 4: intensity times each color channel
	logic                 v_s4, dg_s4;
	logic [2:0][CPW-1:0]  prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				prod_s4[i] <= CPW'(inten_s3) * CPW'(object_rgb_q[CW*(2-i) +: CW]);
			dg_s4 <= dg_s3;
		end
	end

	// stage 5: divide by 255 via reciprocal; flag products past the cap
	logic                v_s5, dg_s5;
	logic [2:0]          over_s5;
	logic [2:0][XW-1:0]  pl_s5;
	logic [2:0][QMW-1:0] qm_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				over_s5[i] <= prod_s4[i] >= LIMIT;
				pl_s5[i]   <= prod_s4[i][XW-1:0];
				qm_s5[i]   <= QMW'(prod_s4[i][XW-1:0]) * QMW'(RECIP);
			end
			dg_s5 <= dg_s4;
		end
	end

	// stage 6: correct the estimate by one, apply the cap
	logic [F:0]   qe_c  [3];
	logic [XW:0]  rem_c [3];
	logic [F:0]   t_c   [3];
	logic         v_s6, dg_s6;
	logic [2:0][F:0] t_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe_c[i]  = qm_s5[i][RK+F:RK];
			rem_c[i] = {1'b0, pl_s5[i]} - ({qe_c[i], 8'b0} - {8'b0, qe_c[i]});
			t_c[i]   = over_s5[i] ? ONE
				: qe_c[i] + (F+1)'(rem_c[i] >= (XW+1)'(255));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				t_s6[i] <= t_c[i];
			dg_s6 <= dg_s5;
		end
	end

	// output register: t*255 >> F, zero color on a degenerate vector
	logic [F+8:0]        scaled_c [3];
	logic [2:0][CW-1:0]  chan_q;
	logic                degenerate_q;

	always_comb begin
		for (int i = 0; i < 3; i++)
			scaled_c[i] = {t_s6[i], 8'b0} - {8'b0, t_s6[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				chan_q[i] <= dg_s6 ? '0 : scaled_c[i][F+CW-1:F];
			degenerate_q <= dg_s6;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = chan_q[0];
	assign green      = chan_q[1];
	assign blue       = chan_q[2];
	assign degenerate = degenerate_q;
endmodule

[rtl/core/bpps_unit.sv]
`timescale 1ns / 1ps
// Pipelined vector normalizer: abs, leading-one search, shift, squares,
// bit-serial square root (one bit per stage), restoring divide (one
// quotient bit per stage). A side tag rides along with each vector.
module bpps_unit #(
	parameter int W  = 16,
	parameter int F  = bpps_pkg::DIR_FRAC_BITS,
	parameter int TW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  in_x,
	input  logic signed [W-1:0]  in_y,
	input  logic signed [W-1:0]  in_z,
	input  logic [TW-1:0]        in_tag,
	output logic                 out_valid,
	output logic signed [F+1:0]  out_x,
	output logic signed [F+1:0]  out_y,
	output logic signed [F+1:0]  out_z,
	output logic                 out_zero,
	output logic [TW-1:0]        out_tag
);
	localparam int NW   = bpps_pkg::NORM_W;
	localparam int PW   = $clog2(W);
	localparam int SQW  = 2 * NW;
	localparam int SUMW = bpps_pkg::SQ_SUM_W;
	localparam int RS   = bpps_pkg::ROOT_STEPS;
	localparam int LW   = bpps_pkg::LEN_W;
	localparam int DS   = F + 1;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [2:0][NW-1:0]   nm;
		logic [TW-1:0]        tag;
	} root_side_t;

	typedef struct packed {
		logic          zero;
		logic [2:0]    neg;
		logic [TW-1:0] tag;
	} div_side_t;

	// stage 1: magnitudes, signs, OR of magnitudes
	logic signed [W-1:0] vin [3];
	logic [W-1:0]        mag_c [3];
	logic                v_s1;
	logic [2:0][W-1:0]   mag_s1;
	logic [2:0]          neg_s1;
	logic [W-1:0]        or_s1;
	logic [TW-1:0]       tag_s1;

	always_comb begin
		vin[0] = in_x;
		vin[1] = in_y;
		vin[2] = in_z;
		for (int i = 0; i < 3; i++)
			mag_c[i] = vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= vin[i][W-1];
			end
			or_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			tag_s1 <= in_tag;
		end
	end

	// stage 2: leading-one position of the largest magnitude
	logic [PW-1:0]     lead_c;
	logic              v_s2;
	logic [PW-1:0]     lead_s2;
	logic              zero_s2;
	logic [2:0][W-1:0] mag_s2;
	logic [2:0]        neg_s2;
	logic [TW-1:0]     tag_s2;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < W; i++)
			if (or_s1[i]) lead_c = PW'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lead_s2 <= lead_c;
			zero_s2 <= (or_s1 == '0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			tag_s2  <= tag_s1;
		end
	end

	// stage 3: shift so the leading one sits at bit NW-1
	logic [PW:0]        sh_c;
	logic [W+NW-1:0]    wide_c [3];
	logic               v_s3;
	logic [2:0][NW-1:0] nm_s3;
	logic               zero_s3;
	logic [2:0]         neg_s3;
	logic [TW-1:0]      tag_s3;

	assign sh_c = {1'b0, lead_s2} + (PW+1)'(1);

	always_comb begin
		for (int i = 0; i < 3; i++)
			wide_c[i] = {mag_s2[i], {NW{1'b0}}} >> sh_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				nm_s3[i] <= wide_c[i][NW-1:0];
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			tag_s3  <= tag_s2;
		end
	end

	// stage 4: squares
	logic                v_s4;
	logic [2:0][SQW-1:0] sq_s4;
	logic [2:0][NW-1:0]  nm_s4;
	logic                zero_s4;
	logic [2:0]          neg_s4;
	logic [TW-1:0]       tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= SQW'(nm_s3[i]) * SQW'(nm_s3[i]);
			nm_s4   <= nm_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			tag_s4  <= tag_s3;
		end
	end

	// stage 5: sum of squares, loaded as square root step zero
	logic [SUMW-1:0] rx_s    [RS+1];
	logic [SUMW-1:0] rr_s    [RS+1];
	logic            rv_s    [RS+1];
	root_side_t      rside_s [RS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s[0] <= 1'b0;
		else if (en) rv_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]    <= SUMW'(sq_s4[0]) + SUMW'(sq_s4[1]) + SUMW'(sq_s4[2]);
			rr_s[0]    <= '0;
			rside_s[0] <= '{zero: zero_s4, neg: neg_s4, nm: nm_s4, tag: tag_s4};
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam logic [SUMW-1:0] BIT = SUMW'(1) << (2 * (RS - 1 - k));
		logic [SUMW:0] trial;

		assign trial = {1'b0, rr_s[k]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[k+1] <= 1'b0;
			else if (en) rv_s[k+1] <= rv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rside_s[k+1] <= rside_s[k];
				if ({1'b0, rx_s[k]} >= trial) begin
					rx_s[k+1] <= rx_s[k] - trial[SUMW-1:0];
					rr_s[k+1] <= (rr_s[k] >> 1) + BIT;
				end else begin
					rx_s[k+1] <= rx_s[k];
					rr_s[k+1] <= rr_s[k] >> 1;
				end
			end
		end
	end

	// restoring divide: (mag << F) / len, one quotient bit per stage
	logic                v_ds     [1:DS];
	logic [LW-1:0]       len_ds   [1:DS];
	div_side_t           dside_ds [1:DS];
	logic [2:0][LW-1:0]  rem_ds   [1:DS];
	logic [2:0][DS-1:0]  q_ds     [1:DS];

	for (genvar d = 0; d < DS; d++) begin : g_div
		logic [LW-1:0] rem_i [3];
		logic [DS-1:0] q_i   [3];
		logic          bit_i [3];
		logic [LW-1:0] len_i;
		logic          v_i;
		div_side_t     side_i;
		logic [LW:0]   t_c   [3];
		logic          ge_c  [3];

		if (d == 0) begin : g_first
			root_side_t rs;
			assign rs = rside_s[RS];
			always_comb begin
				len_i  = rr_s[RS][LW-1:0];
				v_i    = rv_s[RS];
				side_i = '{zero: rs.zero, neg: rs.neg, tag: rs.tag};
				for (int c = 0; c < 3; c++) begin
					rem_i[c] = LW'(rs.nm[c] >> 1);
					q_i[c]   = '0;
					bit_i[c] = rs.nm[c][0];
				end
			end
		end else begin : g_next
			always_comb begin
				len_i  = len_ds[d];
				v_i    = v_ds[d];
				side_i = dside_ds[d];
				for (int c = 0; c < 3; c++) begin
					rem_i[c] = rem_ds[d][c];
					q_i[c]   = q_ds[d][c];
					bit_i[c] = 1'b0;
				end
			end
		end

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				t_c[c]  = {rem_i[c], bit_i[c]};
				ge_c[c] = t_c[c] >= {1'b0, len_i};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_ds[d+1] <= 1'b0;
			else if (en) v_ds[d+1] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_ds[d+1]   <= len_i;
				dside_ds[d+1] <= side_i;
				for (int c = 0; c < 3; c++) begin
					rem_ds[d+1][c] <= ge_c[c] ? LW'(t_c[c] - {1'b0, len_i})
						: t_c[c][LW-1:0];
					q_ds[d+1][c] <= {q_i[c][DS-2:0], ge_c[c]};
				end
			end
		end
	end

	// apply signs
	logic signed [F+1:0] u_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			u_c[c] = dside_ds[DS].neg[c] ? -$signed({1'b0, q_ds[DS][c]})
				: $signed({1'b0, q_ds[DS][c]});
	end

	assign out_valid = v_ds[DS];
	assign out_x     = u_c[0];
	assign out_y     = u_c[1];
	assign out_z     = u_c[2];
	assign out_zero  = dside_ds[DS].zero;
	assign out_tag   = dside_ds[DS].tag;
endmodule

[rtl/core/bpps_chk.sv]
`timescale 1ns / 1ps
module bpps_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bpps_pkg::CHAN_W-1:0] red,
	input logic [bpps_pkg::CHAN_W-1:0] green,
	input logic [bpps_pkg::CHAN_W-1:0] blue,
	input logic                        degenerate
);
	// held beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(degenerate))
		else $error("output beat changed while stalled");

	// degenerate beats carry black
	a_dg_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> red == '0 && green == '0 && blue == '0)
		else $error("degenerate beat with nonzero color");

	// empty output never back-pressures the input
	a_free_run: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");

	// a held output stalls the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");
endmodule

bind blinn_phong_pixel_shader bpps_chk u_bpps_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.red(red),
	.green(green),
	.blue(blue),
	.degenerate(degenerate)
);

[tb/bpps_checker.sv]
`timescale 1ns / 1ps
module bpps_checker
	import bpps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [DIR_W-1:0]      normal_x,
	input  logic [DIR_W-1:0]      normal_y,
	input  logic [DIR_W-1:0]      normal_z,
	input  logic [POS_W-1:0]      pos_x,
	input  logic [POS_W-1:0]      pos_y,
	input  logic [POS_W-1:0]      pos_z,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	input  logic                  degenerate,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    degen_seen
);
	localparam int FB = DIR_FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FB;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} vec3_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              degen;
	} pixel_t;

	logic signed [DIR_W-1:0] light_x, light_y, light_z;
	logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
	logic [RGB_W-1:0]        obj_rgb;
	pixel_t                  shade_q[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] val);
		logic [63:0] x, r, b;
		x = val;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector in Q(FB); returns 0 for a zero vector
	function automatic bit unit_vec(input vec3_t v, output vec3_t u);
		logic signed [63:0] c[3];
		logic [63:0] a[3];
		logic [63:0] mx, sq, len, q;
		c[0] = v.x;
		c[1] = v.y;
		c[2] = v.z;
		mx = 0;
		u = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = c[i] < 0 ? -c[i] : c[i];
			if (a[i] > mx)
				mx = a[i];
		end
		if (mx == 0)
			return 0;
		while (mx >= 64'h8000_0000) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++)
				a[i] = a[i] >> 1;
		end
		while (mx < 64'h4000_0000) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++)
				a[i] = a[i] << 1;
		end
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] << FB) / len;
			c[i] = c[i] < 0 ? -$signed(q) : $signed(q);
		end
		u.x = c[0];
		u.y = c[1];
		u.z = c[2];
		return 1;
	endfunction

	function automatic logic [63:0] clamp_dot(input vec3_t a, input vec3_t b);
		logic signed [63:0] d;
		logic [63:0] r;
		d = a.x * b.x + a.y * b.y + a.z * b.z;
		if (d <= 0)
			return 0;
		r = d >>> FB;
		return r > ONE ? ONE : r;
	endfunction

	function automatic pixel_t shade_pixel(input logic signed [DIR_W-1:0] nx,
			input logic signed [DIR_W-1:0] ny, input logic signed [DIR_W-1:0] nz,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [POS_W-1:0] pz);
		vec3_t nv, lv, vv, hv, n, l, v, h;
		logic [63:0] diff, spec, inten, c, t;
		logic [7:0] ch[3];
		bit ok;
		pixel_t p;
		nv.x = nx;
		nv.y = ny;
		nv.z = nz;
		lv.x = -64'(light_x);
		lv.y = -64'(light_y);
		lv.z = -64'(light_z);
		vv.x = 64'(cam_x) - 64'(px);
		vv.y = 64'(cam_y) - 64'(py);
		vv.z = 64'(cam_z) - 64'(pz);
		ok = unit_vec(nv, n);
		ok = unit_vec(lv, l) && ok;
		ok = unit_vec(vv, v) && ok;
		if (ok) begin
			hv.x = l.x + v.x;
			hv.y = l.y + v.y;
			hv.z = l.z + v.z;
			ok = unit_vec(hv, h);
		end
		p = '0;
		if (!ok) begin
			p.degen = 1'b1;
			return p;
		end
		diff = clamp_dot(n, l);
		spec = clamp_dot(n, h);
		// exponent 64 by six squarings
		for (int i = 0; i < 6; i++)
			spec = (spec * spec) >> FB;
		inten = ((64'd15 << FB) / 100) + diff + (spec >> 1);
		for (int i = 0; i < 3; i++) begin
			c = (obj_rgb >> (16 - 8 * i)) & 64'hFF;
			t = inten * c / 255;
			if (t > ONE)
				t = ONE;
			ch[i] = 8'((t * 255) >> FB);
		end
		p.r = ch[0];
		p.g = ch[1];
		p.b = ch[2];
		return p;
	endfunction

	assign pending = shade_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			light_x = LIGHT_X_RST;
			light_y = LIGHT_Y_RST;
			light_z = LIGHT_Z_RST;
			cam_x = CAMERA_X_RST;
			cam_y = CAMERA_Y_RST;
			cam_z = CAMERA_Z_RST;
			obj_rgb = OBJECT_RGB_RST;
			shade_q.delete();
			errors = 0;
			degen_seen = 0;
		end else begin
			// retire a result before queuing new work from the same edge
			if (out_valid && out_ready) begin
				if (shade_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result r=%0d g=%0d b=%0d degen=%0b",
							$realtime, red, green, blue, degenerate);
				end else begin
					exp_px = shade_q.pop_front();
					if (exp_px.degen)
						degen_seen++;
					if (red !== exp_px.r || green !== exp_px.g || blue !== exp_px.b ||
							degenerate !== exp_px.degen) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp r=%0d g=%0d b=%0d degen=%0b, got r=%0d g=%0d b=%0d degen=%0b",
								$realtime, exp_px.r, exp_px.g, exp_px.b, exp_px.degen,
								red, green, blue, degenerate);
					end
				end
			end
			if (in_valid && in_ready)
				shade_q.insert(shade_q.size(), shade_pixel(normal_x, normal_y, normal_z,
					pos_x, pos_y, pos_z));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LIGHT_X:    light_x = cfg_data[DIR_W-1:0];
					CFG_LIGHT_Y:    light_y = cfg_data[DIR_W-1:0];
					CFG_LIGHT_Z:    light_z = cfg_data[DIR_W-1:0];
					CFG_CAMERA_X:   cam_x = cfg_data;
					CFG_CAMERA_Y:   cam_y = cfg_data;
					CFG_CAMERA_Z:   cam_z = cfg_data;
					CFG_OBJECT_RGB: obj_rgb = cfg_data[RGB_W-1:0];
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import bpps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
	// pipeline depth at the default fraction width, plus margin
	localparam int DRAIN_CYCLES = 2 * DIR_FRAC_BITS + 89 + 30;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 270;
	// long hold-off starts early in a random scene so fragments keep coming
	localparam int HOLD_AFTER    = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DIR_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAN_W-1:0] red, green, blue;
	logic degenerate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors, pending, degen_seen;
	int cycles = 0;
	int frags_sent = 0;
	int cfg_writes = 0;
	// current camera, used to aim fragments near it
	logic signed [POS_W-1:0] cam_cur[3];

	always #5 clk = ~clk;

	blinn_phong_pixel_shader dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue), .degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bpps_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue), .degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .degen_seen(degen_seen)
	);

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, bursts of full readiness, and one long
	// hold-off so the pipe fills and in_ready drops while fragments keep coming.
	initial begin
		bit held_off;
		int mode_left;
		bit eager;
		held_off = 0;
		mode_left = 0;
		eager = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && frags_sent >= HOLD_AFTER) begin
				held_off = 1;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			if (mode_left == 0) begin
				eager = $urandom_range(0, 3) == 0;
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (eager)
				out_ready <= 1'b1;
			else if ($urandom_range(0, 9) < 7)
				out_ready <= 1'b1;
			else if ($urandom_range(0, 19) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 50)) @(posedge clk);
			end else
				out_ready <= 1'b0;
		end
	end

	// Write one register; cfg_ready may be high already, still wait the beat.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_CAMERA_X: cam_cur[0] = val;
			CFG_CAMERA_Y: cam_cur[1] = val;
			CFG_CAMERA_Z: cam_cur[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_scene(input logic signed [15:0] lx, input logic signed [15:0] ly,
			input logic signed [15:0] lz, input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz,
			input logic [23:0] rgb);
		write_reg(CFG_LIGHT_X, 32'(lx));
		write_reg(CFG_LIGHT_Y, 32'(ly));
		write_reg(CFG_LIGHT_Z, 32'(lz));
		write_reg(CFG_CAMERA_X, cx);
		write_reg(CFG_CAMERA_Y, cy);
		write_reg(CFG_CAMERA_Z, cz);
		write_reg(CFG_OBJECT_RGB, 32'(rgb));
	endtask

	// Offer one fragment, with an optional idle gap ahead of it; hold until accepted.
	task automatic send_frag(input logic signed [15:0] nx, input logic signed [15:0] ny,
			input logic signed [15:0] nz, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz, input bit gaps);
		int g;
		g = 0;
		if (gaps && $urandom_range(0, 9) >= 7)
			g = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (!in_ready);
		frags_sent++;
	endtask

	// Drop valid, wait for every outstanding result, then let the pipe empty.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_frag(input bit gaps);
		logic signed [15:0] n[3];
		logic signed [31:0] p[3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 9))
				0, 1:    n[i] = 16'($urandom);
				9:       n[i] = 16'sd0;
				default: n[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
			endcase
			// mostly near the camera so the highlight term matters
			if ($urandom_range(0, 4) == 0)
				p[i] = $urandom;
			else
				p[i] = cam_cur[i] + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
		end
		if ($urandom_range(0, 99) == 0)
			for (int i = 0; i < 3; i++)
				p[i] = cam_cur[i];
		send_frag(n[0], n[1], n[2], p[0], p[1], p[2], gaps);
	endtask

	initial begin
		logic signed [15:0] lrand[3];
		cam_cur[0] = CAMERA_X_RST;
		cam_cur[1] = CAMERA_Y_RST;
		cam_cur[2] = CAMERA_Z_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset scene: normal extremes, zero normal, fragment at the camera.
		send_frag(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sd0, 32'sd0, 32'sd0, 0);
		send_frag(-16'sh8000, -16'sh8000, -16'sh8000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 0);
		send_frag(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 0);
		send_frag(16'sd0, 16'sd16384, 16'sd0, CAMERA_X_RST, CAMERA_Y_RST, CAMERA_Z_RST, 0);
		send_frag(-16'sd11148, -16'sd4460, 16'sd11148, -32'sh8000_0000, -32'sh8000_0000,
			-32'sh8000_0000, 0);
		send_frag(16'sd11148, 16'sd4460, -16'sd11148, 32'sd0, 32'sd0, 32'sd0, 0);
		drain();

		// Light straight down z, camera at origin, white object. A view vector
		// along +z cancels the light exactly, so the halfway vector vanishes.
		write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
		set_scene(16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 24'hFFFFFF);
		set_scene(16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd0, 24'hFFFFFF);
		send_frag(16'sd0, 16'sd0, -16'sd16384, 32'sd0, 32'sd0, -32'sd65536, 0);
		send_frag(16'sd0, 16'sd0, -16'sd16384, 32'sd0, 32'sd0, 32'sd65536, 0);
		send_frag(16'sd0, 16'sd0, -16'sd16384, 32'sd0, 32'sd0, 32'sd1, 0);
		send_frag(16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd65536, 0);
		send_frag(16'sd1, 16'sd0, 16'sd0, 32'sd65536, 32'sd0, 32'sd0, 0);
		send_frag(16'sh7FFF, 16'sd0, -16'sh8000, 32'sd0, 32'sd1, 32'sd0, 0);
		drain();

		// Register extremes: largest light components, camera at both ends.
		set_scene(-16'sd16384, -16'sd16384, -16'sd16384, -32'sh8000_0000, 32'sh7FFF_FFFF,
			-32'sh8000_0000, 24'h000000);
		send_frag(16'sd100, 16'sd100, 16'sd100, 32'sh7FFF_FFFF, -32'sh8000_0000,
			32'sh7FFF_FFFF, 0);
		send_frag(16'sd1, 16'sd1, 16'sd1, 32'sd0, 32'sd0, 32'sd0, 0);
		drain();
		set_scene(16'sh7FFF, -16'sh8000, 16'sd16384, 32'sh7FFF_FFFF, -32'sh8000_0000,
			32'sh7FFF_FFFF, 24'hFF00FF);
		send_frag(16'sd16384, 16'sd16384, 16'sd16384, -32'sh8000_0000, 32'sh7FFF_FFFF,
			-32'sh8000_0000, 0);
		send_frag(-16'sd5000, 16'sd7000, 16'sd100, 32'sd0, 32'sd0, 32'sd0, 0);
		drain();

		// Random scenes; the first keeps the reset-like light to hit highlights.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int i = 0; i < 3; i++)
				lrand[i] = $urandom_range(0, 3) == 0 ? 16'($urandom)
					: 16'($signed($urandom_range(0, 32768)) - 16384);
			if (ph == 0)
				set_scene(-16'sd11148, -16'sd4460, 16'sd11148, 32'sd0, 32'sd327680,
					-32'sd1310720, 24'hFFFFFF);
			else
				set_scene(lrand[0], lrand[1], lrand[2],
					$urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23),
					$urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23),
					$urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23),
					24'($urandom));
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_frag(1);
			// sender pause until every result is back
			drain();
		end

		$display("sent %0d fragments (%0d degenerate) over %0d register writes, %0d cycles",
			frags_sent, degen_seen, cfg_writes, cycles);
		$display("covered reset, axis and extreme scenes plus %0d random scenes",
			RANDOM_PHASES);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[blinn_phong_pixel_shader.f]
rtl/core/bpps_pkg.sv
rtl/core/bpps_unit.sv
rtl/core/blinn_phong_pixel_shader.sv
rtl/core/bpps_chk.sv
tb/bpps_checker.sv
tb/tb_top.sv
